>>> rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the paste text risk scanner: character codes,
// register indexes, the fixed command pattern table and the matcher flags.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  // Width of one UTF-16 code unit
  localparam int unsigned UNIT_W = 16;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_CNT_W   = 32;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WARN_MULTILINE        = 3'd0,
    REG_WARN_TRAILING_NEWLINE = 3'd1,
    REG_WARN_LARGE            = 3'd2,
    REG_LARGE_THRESHOLD       = 3'd3,
    REG_WARN_SUSPICIOUS       = 3'd4
  } pts_reg_t;

  localparam logic [CFG_DATA_W-1:0] LARGE_THRESHOLD_RST = 32'd5120;

  // Character codes
  localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
  localparam logic [UNIT_W-1:0] CH_LF     = 16'h000A;
  localparam logic [UNIT_W-1:0] CH_CR     = 16'h000D;
  localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_AMP    = 16'h0026;
  localparam logic [UNIT_W-1:0] CH_SEMI   = 16'h003B;
  localparam logic [UNIT_W-1:0] CH_UP_A   = 16'h0041;
  localparam logic [UNIT_W-1:0] CH_UP_Z   = 16'h005A;
  localparam logic [UNIT_W-1:0] CH_PIPE   = 16'h007C;
  localparam logic [UNIT_W-1:0] CASE_FOLD = 16'h0020;

  // Dangerous command patterns; the last character sits in the low byte
  localparam int unsigned PAT_COUNT = 9;
  localparam int unsigned PAT_MAX   = 27;
  // Units seen by the matcher: the incoming one plus PAT_MAX-1 earlier ones
  localparam int unsigned HIST_LEN  = PAT_MAX;

  localparam int unsigned PAT_LEN [PAT_COUNT] = '{6, 27, 7, 8, 9, 13, 9, 11, 17};

  localparam logic [PAT_MAX*8-1:0] PAT_TEXT [PAT_COUNT] = '{
    "rm -rf",
    "remove-item -recurse -force",
    "format ",
    "diskpart",
    "shutdown ",
    "stop-computer",
    "del /s /q",
    "rmdir /s /q",
    "invoke-expression"
  };

  // Matcher flags for one incoming unit
  typedef struct packed {
    logic separator;
    logic pattern;
  } pts_hit_t;

endpackage

`default_nettype wire

>>> rtl/pts_matcher.sv
// ----------------------------------------------------------------------------
// pts_matcher
// Compares the lowercased history (incoming unit first, then older units)
// against the command separators and the fixed dangerous patterns, all in
// parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_matcher
  import pts_pkg::*;
(
  input  logic [HIST_LEN-1:0][UNIT_W-1:0] hist,
  output pts_hit_t                         hit
);

  logic pat_ok;
  logic any_pat;

  // Separators end at the incoming unit
  assign hit.separator = (hist[0] == CH_SEMI)
                       || (hist[0] == CH_AMP  && hist[1] == CH_AMP)
                       || (hist[0] == CH_PIPE && hist[1] == CH_PIPE);

  // Each pattern checks its own length of history
  always_comb begin
    any_pat = 1'b0;
    pat_ok  = 1'b0;
    for (int p = 0; p < PAT_COUNT; p++) begin
      pat_ok = 1'b1;
      for (int i = 0; i < PAT_MAX; i++) begin
        if (i < PAT_LEN[p]) begin
          if (hist[i] != {8'h00, PAT_TEXT[p][8*i +: 8]}) begin
            pat_ok = 1'b0;
          end
        end
      end
      any_pat = any_pat | pat_ok;
    end
  end

  assign hit.pattern = any_pat;

endmodule

`default_nettype wire

>>> rtl/paste_text_risk_scanner.sv
// ----------------------------------------------------------------------------
// paste_text_risk_scanner
// Scans pasted text one code unit per cycle while ready, keeps counts and risk
// flags, and emits one summary with configurable reasons when the paste closes.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Moves                                  | Handshake
//  s_axis   | in        | code unit, has_char (tuser), is_last   | tvalid/tready
//  m_axis   | out       | counts, newline end, reason flags      | tvalid/tready
//  cfg      | in        | register index + data                  | valid/ready
//
//  One code unit is taken per cycle; scan state updates at the accept edge.
//  A closing request's summary is registered into out_data or the skid entry.
//  A two-entry output buffer lets scanning go on while a summary waits;
//  s_axis_tready drops only once both entries hold summaries.
//  Reset (rst, synchronous) clears the scan and the output buffer and restores
//  register defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module paste_text_risk_scanner
  import pts_pkg::*;
#(
  parameter int unsigned COUNT_BITS    = 32,
  parameter int unsigned WINDOW_LENGTH = 26
)(
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] code_unit
  input  logic                   s_axis_tuser,   // [0] has_char
  input  logic                   s_axis_tlast,   // is_last
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] char_total,
                                                 // [63:32] line_total,
                                                 // [64] ends_in_newline,
                                                 // [65] reason_multiline,
                                                 // [66] reason_trailing,
                                                 // [67] reason_large,
                                                 // [68] reason_control,
                                                 // [69] reason_separator,
                                                 // [70] reason_suspicious,
                                                 // [71] needs_confirm
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned EXT_W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Configuration registers
  logic                  warn_multiline;
  logic                  warn_trailing_newline;
  logic                  warn_large;
  logic [CFG_DATA_W-1:0] large_threshold;
  logic                  warn_suspicious;

  // Scan state
  logic [COUNT_BITS-1:0]                 unit_count;
  logic [COUNT_BITS-1:0]                 line_count;   // min(newlines + 1, top)
  logic                                  nonempty;
  logic [WINDOW_LENGTH-1:0][UNIT_W-1:0]  window;       // newest at index 0
  logic                                  last_nl;
  logic                                  control_seen;
  logic                                  separator_seen;
  logic                                  pattern_seen;

  logic [COUNT_BITS-1:0] unit_count_next;
  logic [COUNT_BITS-1:0] line_count_next;
  logic                  nonempty_next;
  logic                  last_nl_next;
  logic                  control_next;
  logic                  separator_next;
  logic                  pattern_next;

  // Output buffer
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   skid_valid;
  logic [OUT_TDATA_W-1:0] skid_data;

  logic                   take;
  logic                   take_char;
  logic                   push;
  logic                   pop;
  logic [UNIT_W-1:0]      unit;
  logic [UNIT_W-1:0]      low;
  logic                   is_lf;
  logic                   is_cr;
  logic                   is_ctrl;
  logic [HIST_LEN-1:0][UNIT_W-1:0] hist;
  pts_hit_t               hit;

  logic [EXT_W-1:0]       units_ext;
  logic [EXT_W-1:0]       lines_ext;
  logic [COUNT_BITS-1:0]  lines_val;
  logic                   r_multi;
  logic                   r_trail;
  logic                   r_large;
  logic                   r_susp;
  logic [OUT_TDATA_W-1:0] result;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign take      = s_axis_tvalid && s_axis_tready;
  assign take_char = take && s_axis_tuser;
  assign push      = take && s_axis_tlast;
  assign pop       = out_valid && m_axis_tready;

  // Character classes and ASCII case fold
  assign unit    = s_axis_tdata[UNIT_W-1:0];
  assign is_lf   = (unit == CH_LF);
  assign is_cr   = (unit == CH_CR);
  assign is_ctrl = (unit < CH_SPACE) && !is_lf && !is_cr && (unit != CH_TAB);
  assign low     = (unit >= CH_UP_A && unit <= CH_UP_Z) ? unit + CASE_FOLD : unit;

  // History seen by the matcher
  always_comb begin
    hist[0] = low;
    for (int i = 1; i < HIST_LEN; i++) begin
      hist[i] = window[i-1];
    end
  end

  pts_matcher u_matcher (
    .hist (hist),
    .hit  (hit)
  );

  // Next scan state for the incoming request
  always_comb begin
    unit_count_next = unit_count;
    line_count_next = line_count;
    nonempty_next   = nonempty;
    last_nl_next    = last_nl;
    control_next    = control_seen;
    separator_next  = separator_seen;
    pattern_next    = pattern_seen;
    if (take_char) begin
      if (unit_count != COUNT_TOP) begin
        unit_count_next = unit_count + COUNT_ONE;
      end
      if (is_lf && line_count != COUNT_TOP) begin
        line_count_next = line_count + COUNT_ONE;
      end
      nonempty_next  = 1'b1;
      last_nl_next   = is_lf || is_cr;
      control_next   = control_seen || is_ctrl;
      separator_next = separator_seen || hit.separator;
      pattern_next   = pattern_seen || hit.pattern;
    end
  end

  // Summary of the paste as it stands after this request
  assign lines_val = nonempty_next ? line_count_next : '0;
  assign units_ext = EXT_W'(unit_count_next);
  assign lines_ext = EXT_W'(lines_val);
  assign r_multi   = warn_multiline && (lines_val > COUNT_ONE);
  assign r_trail   = warn_trailing_newline && last_nl_next;
  assign r_large   = warn_large && (units_ext > EXT_W'(large_threshold));
  assign r_susp    = warn_suspicious && pattern_next;

  assign result = {
    r_multi || r_trail || r_large || control_next || separator_next || r_susp,
    r_susp,
    separator_next,
    control_next,
    r_large,
    r_trail,
    r_multi,
    last_nl_next,
    lines_ext[OUT_CNT_W-1:0],
    units_ext[OUT_CNT_W-1:0]
  };

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_multiline        <= 1'b1;
      warn_trailing_newline <= 1'b1;
      warn_large            <= 1'b1;
      large_threshold       <= LARGE_THRESHOLD_RST;
      warn_suspicious       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (pts_reg_t'(cfg_index))
        REG_WARN_MULTILINE:        warn_multiline        <= cfg_data[0];
        REG_WARN_TRAILING_NEWLINE: warn_trailing_newline <= cfg_data[0];
        REG_WARN_LARGE:            warn_large            <= cfg_data[0];
        REG_LARGE_THRESHOLD:       large_threshold       <= cfg_data;
        REG_WARN_SUSPICIOUS:       warn_suspicious       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Scan state; a closing request clears it
  always_ff @(posedge clk) begin
    if (rst || push) begin
      unit_count     <= '0;
      line_count     <= COUNT_ONE;
      nonempty       <= 1'b0;
      window         <= '0;
      last_nl        <= 1'b0;
      control_seen   <= 1'b0;
      separator_seen <= 1'b0;
      pattern_seen   <= 1'b0;
    end else begin
      unit_count     <= unit_count_next;
      line_count     <= line_count_next;
      nonempty       <= nonempty_next;
      last_nl        <= last_nl_next;
      control_seen   <= control_next;
      separator_seen <= separator_next;
      pattern_seen   <= pattern_next;
      if (take_char) begin
        window <= {window[WINDOW_LENGTH-2:0], low};
      end
    end
  end

  // Two-entry output buffer, oldest summary in out_data
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= result;
      end
    end else if (push) begin
      skid_data <= result;
    end
  end

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    push |=> (unit_count == '0 && !nonempty && !pattern_seen))
    else $error("scan state not cleared after closing request");

  a_confirm_or: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[71] == (|m_axis_tdata[70:65])))
    else $error("needs_confirm differs from OR of reasons");

  a_buffer_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready && push) |=> !s_axis_tready)
    else $error("input still ready with both summary entries full");

endmodule

`default_nettype wire

>>> sim/pts_scan_checker.sv
// ----------------------------------------------------------------------------
// pts_scan_checker
// Watches the input, result and register channels of the paste scanner,
// predicts one summary per closing request and compares every accepted
// summary field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pts_scan_checker
  import pts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   end_check,
  output int                     due_count,
  output int                     fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 26;
  localparam int NUM_CMDS   = 9;

  // One summary as it sits on m_axis_tdata, top bit first
  typedef struct packed {
    logic        needs_confirm;
    logic        why_commands;
    logic        why_separator;
    logic        why_control;
    logic        why_large;
    logic        why_trailing;
    logic        why_lines;
    logic        ends_nl;
    logic [31:0] lines;
    logic [31:0] chars;
  } paste_summary_t;

  // Register copies
  logic        warn_lines, warn_trail, warn_big, warn_cmds;
  logic [31:0] big_limit;

  // Running facts about the open paste
  logic [31:0]       unit_total, lf_total;
  logic [UNIT_W-1:0] recent [HIST_DEPTH];
  logic              nl_end, ctrl_hit, sep_hit, cmd_hit;

  paste_summary_t summaries_due [$];
  bit             end_checked = 0;

  function automatic string danger_cmd(int k);
    case (k)
      0: return "rm -rf";
      1: return "remove-item -recurse -force";
      2: return "format ";
      3: return "diskpart";
      4: return "shutdown ";
      5: return "stop-computer";
      6: return "del /s /q";
      7: return "rmdir /s /q";
      default: return "invoke-expression";
    endcase
  endfunction

  // Command text ends at the incoming (folded) unit; older units from recent[]
  function automatic logic cmd_ends_here(logic [UNIT_W-1:0] cur, string cmd);
    int n;
    int i;
    n = cmd.len();
    if (cur != {8'h00, cmd[n-1]})
      return 1'b0;
    for (i = 0; i < n - 1; i++)
      if (recent[i] != {8'h00, cmd[n-2-i]})
        return 1'b0;
    return 1'b1;
  endfunction

  task automatic clear_scan();
    int i;
    unit_total = '0;
    lf_total   = '0;
    for (i = 0; i < HIST_DEPTH; i++)
      recent[i] = '0;
    nl_end   = 1'b0;
    ctrl_hit = 1'b0;
    sep_hit  = 1'b0;
    cmd_hit  = 1'b0;
  endtask

  task automatic scan_unit(logic [UNIT_W-1:0] u);
    logic [UNIT_W-1:0] folded;
    int                k;
    if (unit_total != '1)
      unit_total++;
    if (u == CH_LF && lf_total != '1)
      lf_total++;
    nl_end = (u == CH_LF || u == CH_CR);
    if (u < CH_SPACE && u != CH_CR && u != CH_LF && u != CH_TAB)
      ctrl_hit = 1'b1;
    folded = (u >= CH_UP_A && u <= CH_UP_Z) ? u + CASE_FOLD : u;
    if (folded == CH_SEMI || (folded == CH_AMP && recent[0] == CH_AMP) ||
        (folded == CH_PIPE && recent[0] == CH_PIPE))
      sep_hit = 1'b1;
    for (k = 0; k < NUM_CMDS; k++)
      if (cmd_ends_here(folded, danger_cmd(k)))
        cmd_hit = 1'b1;
    for (k = HIST_DEPTH - 1; k > 0; k--)
      recent[k] = recent[k-1];
    recent[0] = folded;
  endtask

  function automatic paste_summary_t close_paste();
    paste_summary_t r;
    logic [31:0]    lines;
    if (unit_total == 0)
      lines = '0;
    else if (lf_total != '1)
      lines = lf_total + 1;
    else
      lines = lf_total;
    r.chars         = unit_total;
    r.lines         = lines;
    r.ends_nl       = nl_end;
    r.why_lines     = warn_lines && (lines > 1);
    r.why_trailing  = warn_trail && nl_end;
    r.why_large     = warn_big && (unit_total > big_limit);
    r.why_control   = ctrl_hit;
    r.why_separator = sep_hit;
    r.why_commands  = warn_cmds && cmd_hit;
    r.needs_confirm = r.why_lines | r.why_trailing | r.why_large |
                      r.why_control | r.why_separator | r.why_commands;
    return r;
  endfunction

  task automatic report(string msg);
    fail_count++;
    if (fail_count <= 100)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Compare, then apply register writes, then predict from the input request
  always @(posedge clk) begin : watch
    paste_summary_t got;
    paste_summary_t want;
    if (rst) begin
      warn_lines = 1'b1;
      warn_trail = 1'b1;
      warn_big   = 1'b1;
      big_limit  = LARGE_THRESHOLD_RST;
      warn_cmds  = 1'b1;
      fail_count = 0;
      clear_scan();
      summaries_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = paste_summary_t'(m_axis_tdata);
        if (summaries_due.size() == 0) begin
          report($sformatf("summary %0h with no closed paste waiting", m_axis_tdata));
        end else begin
          want = summaries_due.pop_front();
          check_field("char_total", got.chars, want.chars);
          check_field("line_total", got.lines, want.lines);
          check_field("ends_in_newline", 32'(got.ends_nl), 32'(want.ends_nl));
          check_field("reason_multiline", 32'(got.why_lines), 32'(want.why_lines));
          check_field("reason_trailing", 32'(got.why_trailing), 32'(want.why_trailing));
          check_field("reason_large", 32'(got.why_large), 32'(want.why_large));
          check_field("reason_control", 32'(got.why_control), 32'(want.why_control));
          check_field("reason_separator", 32'(got.why_separator),
                      32'(want.why_separator));
          check_field("reason_suspicious", 32'(got.why_commands),
                      32'(want.why_commands));
          check_field("needs_confirm", 32'(got.needs_confirm),
                      32'(want.needs_confirm));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WARN_MULTILINE:        warn_lines = cfg_data[0];
          REG_WARN_TRAILING_NEWLINE: warn_trail = cfg_data[0];
          REG_WARN_LARGE:            warn_big   = cfg_data[0];
          REG_LARGE_THRESHOLD:       big_limit  = cfg_data;
          REG_WARN_SUSPICIOUS:       warn_cmds  = cfg_data[0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser)
          scan_unit(s_axis_tdata);
        if (s_axis_tlast) begin
          summaries_due = {summaries_due, close_paste()};
          clear_scan();
        end
      end

      // Anything still owed once stimulus has drained is lost
      if (end_check && !end_checked) begin
        end_checked = 1;
        if (summaries_due.size() != 0)
          report($sformatf("%0d summaries never arrived", summaries_due.size()));
      end
    end
    due_count <= summaries_due.size();
  end

endmodule

>>> sim/paste_text_risk_scanner_tb.sv
// ----------------------------------------------------------------------------
// paste_text_risk_scanner_tb
// Drives pastes into the scanner: a directed opening for empty pastes,
// ignored requests, control units, case folding, separators and commands,
// then random pastes across several register settings with bursty input,
// a stalling receiver and one long receiver hold. A checker beside the
// block predicts and compares every summary.
// ----------------------------------------------------------------------------
module paste_text_risk_scanner_tb
  import pts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD_CYCLES = 400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   end_check = 1'b0;

  int due_count;
  int fail_count;
  int items_sent  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1;
  bit long_hold   = 0;
  bit hold_active = 0;

  paste_text_risk_scanner u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pts_scan_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .end_check     (end_check),
    .due_count     (due_count),
    .fail_count    (fail_count)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random ready pattern, one long hold on request
  initial begin : rx
    int run;
    int pick;
    bit hold_done;
    hold_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold && !hold_done) begin
        hold_done = 1;
        hold_active = 1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        m_axis_tready <= 1'b1;
        run = $urandom_range(1, 12);
      end else if (pick < 8) begin
        m_axis_tready <= 1'b0;
        run = $urandom_range(1, 5);
      end else begin
        m_axis_tready <= 1'b1;
        run = $urandom_range(30, 60);
      end
      repeat (run) @(posedge clk);
    end
  end

  // One input request; valid stays high into the next call unless a gap starts
  task automatic send_item(logic [UNIT_W-1:0] unit, logic has_char, logic closing);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= unit;
    s_axis_tuser  <= has_char;
    s_axis_tlast  <= closing;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_str(string txt, bit closing);
    int i;
    for (i = 0; i < txt.len(); i++)
      send_item({8'h00, txt[i]}, 1'b1, closing && (i == txt.len() - 1));
  endtask

  // Command text: exact, one unit corrupted, or cut short by one; random case
  task automatic send_cmd(int k, int mode, bit closing);
    int       n;
    int       bad;
    int       j;
    logic [7:0] ch;
    n = PAT_LEN[k];
    if (mode == 2)
      n = n - 1;
    bad = (mode == 1) ? $urandom_range(0, n - 1) : -1;
    for (j = 0; j < n; j++) begin
      ch = PAT_TEXT[k][(PAT_LEN[k] - 1 - j) * 8 +: 8];
      if (j == bad)
        ch = 8'($urandom_range(32'h20, 32'h7E));
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 3) == 0)
        ch = ch - CASE_FOLD[7:0];
      send_item({8'h00, ch}, 1'b1, closing && (j == n - 1));
    end
  endtask

  // One paste of random pieces, then a closing request of a random kind
  task automatic send_paste(int max_pieces);
    int n;
    int i;
    int pick;
    logic [UNIT_W-1:0] u;
    n = $urandom_range(0, max_pieces);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_cmd($urandom_range(0, PAT_COUNT - 1),
                 ($urandom_range(0, 4) < 3) ? 0 : $urandom_range(1, 2), 1'b0);
      end else if (pick < 18) begin
        case ($urandom_range(0, 2))
          0: u = CH_AMP;
          1: u = CH_PIPE;
          default: u = CH_SEMI;
        endcase
        repeat ($urandom_range(1, 2)) send_item(u, 1'b1, 1'b0);
      end else if (pick < 26) begin
        send_item($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b1, 1'b0);
      end else if (pick < 31) begin
        send_item(UNIT_W'($urandom_range(0, 31)), 1'b1, 1'b0);
      end else if (pick < 37) begin
        send_item(UNIT_W'($urandom_range(0, 65535)), 1'b1, 1'b0);
      end else if (pick < 41) begin
        send_item(UNIT_W'($urandom_range(0, 65535)), 1'b0, 1'b0);
      end else if (pick < 56) begin
        u = UNIT_W'($urandom_range(CH_UP_A, CH_UP_Z));
        if ($urandom_range(0, 1) != 0)
          u = u + CASE_FOLD;
        send_item(u, 1'b1, 1'b0);
      end else begin
        send_item(UNIT_W'($urandom_range(32'h20, 32'h7E)), 1'b1, 1'b0);
      end
    end
    case ($urandom_range(0, 2))
      0: send_item(UNIT_W'($urandom_range(0, 65535)), 1'b0, 1'b1);
      1: begin
        case ($urandom_range(0, 3))
          0: u = CH_LF;
          1: u = CH_CR;
          2: u = UNIT_W'($urandom_range(0, 65535));
          default: u = UNIT_W'($urandom_range(32'h20, 32'h7E));
        endcase
        send_item(u, 1'b1, 1'b1);
      end
      default: send_cmd($urandom_range(0, PAT_COUNT - 1), $urandom_range(0, 2), 1'b1);
    endcase
  endtask

  // Sender goes quiet until every summary is back, then idles before returning
  task automatic stop_and_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_count != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(pts_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Flag registers get random upper bits, which the block must ignore
  task automatic set_config(bit ml, bit tr, bit lg, logic [31:0] lim, bit su);
    write_reg(REG_WARN_MULTILINE, ($urandom() & 32'hFFFF_FFFE) | ml);
    write_reg(REG_WARN_TRAILING_NEWLINE, ($urandom() & 32'hFFFF_FFFE) | tr);
    write_reg(REG_WARN_LARGE, ($urandom() & 32'hFFFF_FFFE) | lg);
    write_reg(REG_LARGE_THRESHOLD, lim);
    write_reg(REG_WARN_SUSPICIOUS, ($urandom() & 32'hFFFF_FFFE) | su);
  endtask

  task automatic run_phase(int target, int max_pieces);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      send_paste(max_pieces);
      if ($urandom_range(0, 19) == 0)
        stop_and_drain();
    end
    stop_and_drain();
  endtask

  initial begin : stim
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty paste, ignored request, controls and newlines,
    // folded command with separator closed by an empty request, pipes, ampersands
    send_item(16'h0000, 1'b0, 1'b1);
    send_item(16'hFFFF, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'h001F, 1'b1, 1'b0);
    send_item(CH_TAB, 1'b1, 1'b0);
    send_item(CH_LF, 1'b1, 1'b0);
    send_item(CH_CR, 1'b1, 1'b1);
    send_str("Rm -RF;", 1'b0);
    send_item(16'h0000, 1'b0, 1'b1);
    send_str("||", 1'b1);
    send_str("a&&", 1'b1);
    stop_and_drain();

    run_phase(100, 10);

    set_config(1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    run_phase(90, 10);

    // Threshold zero; receiver holds off while short pastes pile up
    set_config(1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b1);
    long_hold = 1;
    while (!hold_active) @(posedge clk);
    gaps_on = 0;
    for (i = 0; i < 30; i++)
      send_paste(2);
    stop_and_drain();
    gaps_on = 1;
    run_phase(90, 3);

    set_config(1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    run_phase(90, 12);

    set_config(1'b0, 1'b1, 1'b1, $urandom_range(1, 40), 1'b1);
    run_phase(90, 8);

    // Back-to-back input, small threshold
    set_config(1'b1, 1'b1, 1'b1, 32'd20, 1'b1);
    gaps_on = 0;
    run_phase(90, 16);
    gaps_on = 1;

    set_config(1'b1, 1'b1, 1'b1, LARGE_THRESHOLD_RST, 1'b1);
    run_phase(70, 6);

    end_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
